// ===== rtl/core/gdc_pkg.sv =====
// Shared types, constants, calendar helpers and the microcode program of the date unit.
package gdc_pkg;

    typedef logic [4:0] upc_t;

    typedef enum logic [2:0] {
        ACT_SET   = 3'd0,
        ACT_ADD   = 3'd1,
        ACT_INC   = 3'd2,
        ACT_DEC   = 3'd3,
        ACT_UNTIL = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CHECK,
        OP_SET_WR,
        OP_INIT_CUR,
        OP_INIT_TGT,
        OP_YEAR_ACC,
        OP_MON_ACC,
        OP_SAVE_ORD,
        OP_SPAN,
        OP_ADJUST,
        OP_LOAD_INIT,
        OP_YEAR_SUB,
        OP_MON_SUB,
        OP_COMMIT,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        H_NONE,
        H_NOACC,
        H_YACC,
        H_MACC,
        H_YSUB,
        H_MSUB,
        H_OUTBUSY
    } hold_t;

    typedef enum logic [1:0] {
        J_NEVER,
        J_ALWAYS,
        J_BAD,
        J_DISPATCH
    } jump_t;

    typedef struct packed {
        op_t   op;
        hold_t hold;
        jump_t jump;
        upc_t  target;
    } ctrl_t;

    localparam upc_t A_IDLE  = 5'd0;
    localparam upc_t A_DISP  = 5'd1;
    localparam upc_t A_SET   = 5'd2;
    localparam upc_t A_UNTIL = 5'd4;
    localparam upc_t A_ADJ   = 5'd14;
    localparam upc_t A_OUT   = 5'd22;

    localparam int        TQ_SHIFT = 17;
    localparam logic [12:0] TQ_MUL = 13'd5243;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    localparam logic [4:0] FEB_LEAP_LEN = 5'd29;
    localparam logic [3:0] FEB = 4'd2;

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [3:0] idx;
        logic [4:0] len;
        idx = m - 4'd1;
        if (idx < 4'd12)
        begin
            len = MONTH_LEN[idx];
        end
        else
        begin
            len = MONTH_LEN[0];
        end
        if (m == FEB && leap)
        begin
            len = FEB_LEAP_LEN;
        end
        return len;
    endfunction

    function automatic upc_t dispatch_addr(input logic [2:0] a);
        upc_t r;
        case (a)
            ACT_SET:   r = A_SET;
            ACT_ADD:   r = A_ADJ;
            ACT_INC:   r = A_ADJ;
            ACT_DEC:   r = A_ADJ;
            ACT_UNTIL: r = A_UNTIL;
            default:   r = A_OUT;
        endcase
        return r;
    endfunction

    function automatic ctrl_t ucode(input upc_t a);
        ctrl_t c;
        case (a)
            5'd0:    c = '{OP_NOP,       H_NOACC,   J_NEVER,    A_IDLE};
            5'd1:    c = '{OP_NOP,       H_NONE,    J_DISPATCH, A_IDLE};
            5'd2:    c = '{OP_CHECK,     H_NONE,    J_NEVER,    A_IDLE};
            5'd3:    c = '{OP_SET_WR,    H_NONE,    J_ALWAYS,   A_OUT};
            5'd4:    c = '{OP_CHECK,     H_NONE,    J_NEVER,    A_IDLE};
            5'd5:    c = '{OP_NOP,       H_NONE,    J_BAD,      A_OUT};
            5'd6:    c = '{OP_INIT_CUR,  H_NONE,    J_NEVER,    A_IDLE};
            5'd7:    c = '{OP_YEAR_ACC,  H_YACC,    J_NEVER,    A_IDLE};
            5'd8:    c = '{OP_MON_ACC,   H_MACC,    J_NEVER,    A_IDLE};
            5'd9:    c = '{OP_SAVE_ORD,  H_NONE,    J_NEVER,    A_IDLE};
            5'd10:   c = '{OP_INIT_TGT,  H_NONE,    J_NEVER,    A_IDLE};
            5'd11:   c = '{OP_YEAR_ACC,  H_YACC,    J_NEVER,    A_IDLE};
            5'd12:   c = '{OP_MON_ACC,   H_MACC,    J_NEVER,    A_IDLE};
            5'd13:   c = '{OP_SPAN,      H_NONE,    J_ALWAYS,   A_OUT};
            5'd14:   c = '{OP_INIT_CUR,  H_NONE,    J_NEVER,    A_IDLE};
            5'd15:   c = '{OP_YEAR_ACC,  H_YACC,    J_NEVER,    A_IDLE};
            5'd16:   c = '{OP_MON_ACC,   H_MACC,    J_NEVER,    A_IDLE};
            5'd17:   c = '{OP_ADJUST,    H_NONE,    J_BAD,      A_OUT};
            5'd18:   c = '{OP_LOAD_INIT, H_NONE,    J_NEVER,    A_IDLE};
            5'd19:   c = '{OP_YEAR_SUB,  H_YSUB,    J_NEVER,    A_IDLE};
            5'd20:   c = '{OP_MON_SUB,   H_MSUB,    J_NEVER,    A_IDLE};
            5'd21:   c = '{OP_COMMIT,    H_NONE,    J_ALWAYS,   A_OUT};
            5'd22:   c = '{OP_EMIT,      H_OUTBUSY, J_ALWAYS,   A_IDLE};
            default: c = '{OP_NOP,       H_NONE,    J_ALWAYS,   A_IDLE};
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/gdc_if.sv =====
// Request and response channel interfaces of the date unit.
interface gdc_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [15:0] count;

    modport source (output valid, action, day, month, year, count, input ready);
    modport sink (input valid, action, day, month, year, count, output ready);
endinterface

interface gdc_rsp_if;
    logic               valid;
    logic               ready;
    logic [4:0]         out_day;
    logic [3:0]         out_month;
    logic [11:0]        out_year;
    logic signed [17:0] span;
    logic [1:0]         status;

    modport source (output valid, out_day, out_month, out_year, span, status, input ready);
    modport sink (input valid, out_day, out_month, out_year, span, status, output ready);
endinterface

// ===== rtl/core/gregorian_date_calendar_unit.sv =====
// Gregorian date register with set, add, step and days-until actions, run by a microcode sequencer.
//
//   channel | dir | transaction
//   --------+-----+-----------------------------------------------------------
//   req     | in  | action, day, month, year, count
//   rsp     | out | out_day, out_month, out_year, span, status
//
// A set only checks and writes the date. A step walks the stored date to a day number, and a
// refused step ends there; otherwise the new day number is walked back to a date. Days-until
// walks the stored date and then the target, and a bad target ends it before either walk.
// The date walker moves one year or one month per cycle. Reset loads 1 January of BASE_YEAR.
// The emit step waits while the output register holds an unaccepted result.
module gregorian_date_calendar_unit #(
    parameter int BASE_YEAR = 2000,
    parameter int YEAR_SPAN = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    gdc_req_if.sink   req,
    gdc_rsp_if.source rsp
);
    import gdc_pkg::*;

    localparam int OFF_W = (YEAR_SPAN > 1) ? $clog2(YEAR_SPAN) : 1;
    localparam int ORD_W = $clog2(YEAR_SPAN * 366 + 65537);
    localparam int END_Y = BASE_YEAR + YEAR_SPAN - 1;
    localparam int PRE_Y = BASE_YEAR - 1;
    localparam int LEAPS_END = END_Y / 4 - END_Y / 100 + END_Y / 400;
    localparam int LEAPS_PRE = PRE_Y / 4 - PRE_Y / 100 + PRE_Y / 400;
    localparam int LAST_ORD = 365 * YEAR_SPAN + LEAPS_END - LEAPS_PRE - 1;
    localparam logic [ORD_W-1:0] LAST_ORD_V = ORD_W'(LAST_ORD);
    localparam logic [14:0] BASE15 = 15'(BASE_YEAR);
    localparam logic [14:0] END15 = 15'(BASE_YEAR + YEAR_SPAN);
    localparam logic [8:0] BASE_MOD = 9'(BASE_YEAR % 400);
    localparam logic [8:0] MOD_LAST = 9'd399;

    upc_t               pc_reg, pc_next;
    logic               out_valid_reg, out_valid_next;
    logic [4:0]         cur_day_reg, cur_day_next;
    logic [3:0]         cur_mon_reg, cur_mon_next;
    logic [OFF_W-1:0]   cur_off_reg, cur_off_next;

    logic [2:0]         act_reg, act_next;
    logic [4:0]         tgt_day_reg, tgt_day_next;
    logic [3:0]         tgt_mon_reg, tgt_mon_next;
    logic [11:0]        tgt_year_reg, tgt_year_next;
    logic [15:0]        cnt_reg, cnt_next;
    logic [7:0]         tq_reg, tq_next;
    status_t            status_reg, status_next;
    logic [17:0]        span_reg, span_next;
    logic [ORD_W-1:0]   acc_reg, acc_next;
    logic [ORD_W-1:0]   ord_a_reg, ord_a_next;
    logic [OFF_W-1:0]   w_off_reg, w_off_next;
    logic [8:0]         c400_reg, c400_next;
    logic [3:0]         w_mon_reg, w_mon_next;
    logic [OFF_W-1:0]   g_off_reg, g_off_next;
    logic [3:0]         g_mon_reg, g_mon_next;
    logic [4:0]         g_day_reg, g_day_next;
    logic [4:0]         o_day_reg, o_day_next;
    logic [3:0]         o_mon_reg, o_mon_next;
    logic [11:0]        o_year_reg, o_year_next;
    logic [17:0]        o_span_reg, o_span_next;
    status_t            o_status_reg, o_status_next;

    ctrl_t              ctrl;
    logic               req_fire;
    logic               out_busy;
    logic               leap_w;
    logic [8:0]         diy_w;
    logic [4:0]         dim_w;
    logic [8:0]         c400_inc;
    logic [24:0]        tq_prod;
    logic [12:0]        tq_times25;
    logic               tgt_d25;
    logic               leap_t;
    logic [14:0]        tgt_y15;
    logic [14:0]        tgt_off15;
    status_t            chk_status;
    logic [ORD_W-1:0]   ord_cur;
    logic [ORD_W-1:0]   step_amt;
    logic [ORD_W-1:0]   n_up;
    logic [14:0]        cur_y15;
    logic               hold_hit;
    logic               jump_hit;

    assign ctrl = ucode(pc_reg);
    assign req.ready = (pc_reg == A_IDLE);
    assign req_fire = req.valid && req.ready;
    assign out_busy = out_valid_reg && !rsp.ready;

    assign leap_w = (c400_reg[1:0] == 2'b00)
                    && !(c400_reg inside {9'd100, 9'd200, 9'd300});
    assign diy_w = leap_w ? 9'd366 : 9'd365;
    assign dim_w = month_days(w_mon_reg, leap_w);
    assign c400_inc = (c400_reg == MOD_LAST) ? 9'd0 : c400_reg + 9'd1;

    assign tq_prod = 25'(tgt_year_reg) * 25'(TQ_MUL);
    assign tq_next = tq_prod[TQ_SHIFT +: 8];
    assign tq_times25 = 13'({tq_reg, 4'b0000}) + 13'({tq_reg, 3'b000}) + 13'(tq_reg);
    assign tgt_d25 = (tq_times25 == 13'(tgt_year_reg));
    assign leap_t = (tgt_year_reg[1:0] == 2'b00) && !(tgt_d25 && tgt_year_reg[3:0] != 4'd0);
    assign tgt_y15 = 15'(tgt_year_reg);
    assign tgt_off15 = tgt_y15 - BASE15;

    always_comb
    begin
        if (!(tgt_mon_reg inside {[4'd1:4'd12]}) || tgt_y15 < BASE15
            || tgt_day_reg == 5'd0)
        begin
            chk_status = ST_INVALID;
        end
        else if (tgt_day_reg > month_days(tgt_mon_reg, leap_t))
        begin
            chk_status = ST_INVALID;
        end
        else if (tgt_y15 >= END15)
        begin
            chk_status = ST_RANGE;
        end
        else
        begin
            chk_status = ST_OK;
        end
    end

    assign ord_cur = acc_reg + ORD_W'(g_day_reg) - ORD_W'(1);
    assign step_amt = (act_reg == ACT_ADD) ? ORD_W'(cnt_reg) : ORD_W'(1);
    assign n_up = ord_cur + step_amt;
    assign cur_y15 = BASE15 + 15'(cur_off_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        cur_day_next   = cur_day_reg;
        cur_mon_next   = cur_mon_reg;
        cur_off_next   = cur_off_reg;
        act_next       = act_reg;
        tgt_day_next   = tgt_day_reg;
        tgt_mon_next   = tgt_mon_reg;
        tgt_year_next  = tgt_year_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        span_next      = span_reg;
        acc_next       = acc_reg;
        ord_a_next     = ord_a_reg;
        w_off_next     = w_off_reg;
        c400_next      = c400_reg;
        w_mon_next     = w_mon_reg;
        g_off_next     = g_off_reg;
        g_mon_next     = g_mon_reg;
        g_day_next     = g_day_reg;
        o_day_next     = o_day_reg;
        o_mon_next     = o_mon_reg;
        o_year_next    = o_year_reg;
        o_span_next    = o_span_reg;
        o_status_next  = o_status_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (req_fire)
        begin
            act_next      = req.action;
            tgt_day_next  = req.day;
            tgt_mon_next  = req.month;
            tgt_year_next = req.year;
            cnt_next      = req.count;
            status_next   = ST_OK;
            span_next     = '0;
        end

        case (ctrl.op)
            OP_NOP:
            begin
            end
            OP_CHECK:
            begin
                status_next = chk_status;
            end
            OP_SET_WR:
            begin
                if (status_reg == ST_OK)
                begin
                    cur_day_next = tgt_day_reg;
                    cur_mon_next = tgt_mon_reg;
                    cur_off_next = tgt_off15[OFF_W-1:0];
                end
            end
            OP_INIT_CUR:
            begin
                acc_next   = '0;
                w_off_next = '0;
                c400_next  = BASE_MOD;
                w_mon_next = 4'd1;
                g_off_next = cur_off_reg;
                g_mon_next = cur_mon_reg;
                g_day_next = cur_day_reg;
            end
            OP_INIT_TGT:
            begin
                acc_next   = '0;
                w_off_next = '0;
                c400_next  = BASE_MOD;
                w_mon_next = 4'd1;
                g_off_next = tgt_off15[OFF_W-1:0];
                g_mon_next = tgt_mon_reg;
                g_day_next = tgt_day_reg;
            end
            OP_YEAR_ACC:
            begin
                if (w_off_reg != g_off_reg)
                begin
                    acc_next   = acc_reg + ORD_W'(diy_w);
                    w_off_next = w_off_reg + OFF_W'(1);
                    c400_next  = c400_inc;
                end
            end
            OP_MON_ACC:
            begin
                if (w_mon_reg != g_mon_reg)
                begin
                    acc_next   = acc_reg + ORD_W'(dim_w);
                    w_mon_next = w_mon_reg + 4'd1;
                end
            end
            OP_SAVE_ORD:
            begin
                ord_a_next = ord_cur;
            end
            OP_SPAN:
            begin
                if (ord_cur < ord_a_reg)
                begin
                    span_next = '1;
                end
                else
                begin
                    span_next = 18'(ord_cur - ord_a_reg);
                end
            end
            OP_ADJUST:
            begin
                if (act_reg == ACT_DEC)
                begin
                    if (ord_cur == '0)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        acc_next = ord_cur - ORD_W'(1);
                    end
                end
                else if (n_up > LAST_ORD_V)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    acc_next = n_up;
                end
            end
            OP_LOAD_INIT:
            begin
                w_off_next = '0;
                c400_next  = BASE_MOD;
                w_mon_next = 4'd1;
            end
            OP_YEAR_SUB:
            begin
                if (acc_reg >= ORD_W'(diy_w))
                begin
                    acc_next   = acc_reg - ORD_W'(diy_w);
                    w_off_next = w_off_reg + OFF_W'(1);
                    c400_next  = c400_inc;
                end
            end
            OP_MON_SUB:
            begin
                if (acc_reg >= ORD_W'(dim_w))
                begin
                    acc_next   = acc_reg - ORD_W'(dim_w);
                    w_mon_next = w_mon_reg + 4'd1;
                end
            end
            OP_COMMIT:
            begin
                cur_day_next = acc_reg[4:0] + 5'd1;
                cur_mon_next = w_mon_reg;
                cur_off_next = w_off_reg;
            end
            OP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    o_day_next     = cur_day_reg;
                    o_mon_next     = cur_mon_reg;
                    o_year_next    = cur_y15[11:0];
                    o_span_next    = span_reg;
                    o_status_next  = status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        case (ctrl.hold)
            H_NONE:    hold_hit = 1'b0;
            H_NOACC:   hold_hit = !req.valid;
            H_YACC:    hold_hit = (w_off_reg != g_off_reg);
            H_MACC:    hold_hit = (w_mon_reg != g_mon_reg);
            H_YSUB:    hold_hit = (acc_reg >= ORD_W'(diy_w));
            H_MSUB:    hold_hit = (acc_reg >= ORD_W'(dim_w));
            H_OUTBUSY: hold_hit = out_busy;
            default:   hold_hit = 1'b0;
        endcase

        case (ctrl.jump)
            J_NEVER:    jump_hit = 1'b0;
            J_ALWAYS:   jump_hit = 1'b1;
            J_BAD:      jump_hit = (status_next != ST_OK);
            J_DISPATCH: jump_hit = 1'b1;
            default:    jump_hit = 1'b0;
        endcase

        if (hold_hit)
        begin
            pc_next = pc_reg;
        end
        else if (jump_hit)
        begin
            pc_next = (ctrl.jump == J_DISPATCH) ? dispatch_addr(act_reg) : ctrl.target;
        end
        else
        begin
            pc_next = pc_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= A_IDLE;
            out_valid_reg <= 1'b0;
            cur_day_reg   <= 5'd1;
            cur_mon_reg   <= 4'd1;
            cur_off_reg   <= '0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            cur_day_reg   <= cur_day_next;
            cur_mon_reg   <= cur_mon_next;
            cur_off_reg   <= cur_off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        tgt_day_reg  <= tgt_day_next;
        tgt_mon_reg  <= tgt_mon_next;
        tgt_year_reg <= tgt_year_next;
        cnt_reg      <= cnt_next;
        tq_reg       <= tq_next;
        status_reg   <= status_next;
        span_reg     <= span_next;
        acc_reg      <= acc_next;
        ord_a_reg    <= ord_a_next;
        w_off_reg    <= w_off_next;
        c400_reg     <= c400_next;
        w_mon_reg    <= w_mon_next;
        g_off_reg    <= g_off_next;
        g_mon_reg    <= g_mon_next;
        g_day_reg    <= g_day_next;
        o_day_reg    <= o_day_next;
        o_mon_reg    <= o_mon_next;
        o_year_reg   <= o_year_next;
        o_span_reg   <= o_span_next;
        o_status_reg <= o_status_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_day   = o_day_reg;
    assign rsp.out_month = o_mon_reg;
    assign rsp.out_year  = o_year_reg;
    assign rsp.span      = $signed(o_span_reg);
    assign rsp.status    = o_status_reg;

    // The stored date is always a legal calendar position.
    a_cur_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cur_mon_reg >= 4'd1 && cur_mon_reg <= 4'd12 && cur_day_reg != 5'd0)
        else $error("stored date out of range");

    // Only the set and commit steps may change the stored date.
    a_cur_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op != OP_SET_WR && ctrl.op != OP_COMMIT)
        |=> $stable({cur_day_reg, cur_mon_reg, cur_off_reg}))
        else $error("stored date changed outside a write step");

    // The year walk never passes its goal year.
    a_year_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == OP_YEAR_ACC |-> w_off_reg <= g_off_reg)
        else $error("year walk overshot its goal");

    // A nonzero span only comes with a successful days-until transaction.
    a_span_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && o_span_reg != '0) |-> o_status_reg == ST_OK)
        else $error("span reported with a failing status");

endmodule
